@@ hw/rtl/ccke_pkg.sv @@
// Shared types, constants and helper functions for the canonical center k-mer extractor.
package ccke_pkg;

    localparam int MAX_K             = 31;
    localparam int MIN_K             = 3;
    localparam int CONTIG_INDEX_BITS = 20;

    localparam int K_W      = 5;
    localparam int CHAR_W   = 8;
    localparam int CODE_W   = 2;
    localparam int CONTIG_W = 20;
    localparam int POS_W    = 32;
    localparam int FLANK_W  = 60;
    localparam int WIN_W    = 2 * MAX_K;
    localparam int SH_W     = $clog2(WIN_W + 1);
    localparam int HALF_W   = $clog2(MAX_K / 2 + 1);

    localparam logic [CONTIG_W-1:0] CONTIG_MASK =
        CONTIG_W'((64'd1 << CONTIG_INDEX_BITS) - 64'd1);

    localparam logic [K_W-1:0] K_RESET = K_W'(MAX_K);

    // Raw characters that form bases
    localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code BASE_A = 2'd0;
    localparam t_code BASE_C = 2'd1;
    localparam t_code BASE_G = 2'd2;
    localparam t_code BASE_T = 2'd3;

    typedef struct packed {
        logic  hit;
        t_code code;
    } t_decode;

    // Stage-one request handed from the window unit to the flank unit
    typedef struct packed {
        logic                vld;
        logic                full;
        logic [WIN_W-1:0]    fwd;
        logic [WIN_W-1:0]    rev;
        logic [HALF_W-1:0]   half;
        logic [POS_W-1:0]    center_position;
        logic [CONTIG_W-1:0] contig_tag;
    } t_stage;

    function automatic t_decode decode_base(input logic [CHAR_W-1:0] ch);
        t_decode d;
        d.hit  = 1'b1;
        d.code = BASE_A;
        unique case (ch) inside
            CHAR_A_UP, CHAR_A_LO: d.code = BASE_A;
            CHAR_C_UP, CHAR_C_LO: d.code = BASE_C;
            CHAR_G_UP, CHAR_G_LO: d.code = BASE_G;
            CHAR_T_UP, CHAR_T_LO: d.code = BASE_T;
            default:              d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    // Ones in the low 2k bits
    function automatic logic [WIN_W-1:0] win_mask(input logic [K_W-1:0] k);
        logic [WIN_W-1:0] m;
        for (int i = 0; i < WIN_W; i++) begin
            m[i] = (SH_W'(i) < SH_W'({k, 1'b0}));
        end
        return m;
    endfunction

    // Drop the base at position half and close the gap
    function automatic logic [FLANK_W-1:0] remove_center(input logic [WIN_W-1:0]  y,
                                                         input logic [HALF_W-1:0] half);
        logic [SH_W-1:0]  sh;
        logic [WIN_W-1:0] right;
        logic [WIN_W-1:0] left;
        sh    = SH_W'({half, 1'b0});
        right = y & ~({WIN_W{1'b1}} << sh);
        left  = (y >> (sh + SH_W'(2))) << sh;
        return FLANK_W'(right | left);
    endfunction

endpackage

@@ hw/rtl/ccke_if.sv @@
// Channel interfaces: sequence characters in, k-mer sites out, length configuration.
interface ccke_in_if;
    logic                            valid;
    logic                            ready;
    logic [ccke_pkg::CHAR_W-1:0]     base_char;
    logic                            seq_start;
    logic [ccke_pkg::CONTIG_W-1:0]   contig_index;

    modport source (output valid, base_char, seq_start, contig_index, input ready);
    modport sink   (input valid, base_char, seq_start, contig_index, output ready);
endinterface

interface ccke_out_if;
    logic                            valid;
    logic                            ready;
    logic [ccke_pkg::FLANK_W-1:0]    flank_bits;
    logic [ccke_pkg::CODE_W-1:0]     center_base;
    logic [ccke_pkg::POS_W-1:0]      center_position;
    logic [ccke_pkg::CONTIG_W-1:0]   contig_tag;

    modport source (output valid, flank_bits, center_base, center_position, contig_tag,
                    input ready);
    modport sink   (input valid, flank_bits, center_base, center_position, contig_tag,
                    output ready);
endinterface

interface ccke_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ccke_pkg::K_W-1:0]    kmer_length;

    modport source (output valid, kmer_length, input ready);
    modport sink   (input valid, kmer_length, output ready);
endinterface

@@ hw/rtl/ccke_window.sv @@
// Rolling forward and reverse-complement windows, run count and position (stage one).
module ccke_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ccke_cfg_if.sink             i_cfg,
    ccke_in_if.sink              i_kmer,
    input  logic                 i_take,
    output ccke_pkg::t_stage     o_stage
);

    logic [ccke_pkg::K_W-1:0]      r_kmer_length;
    logic [ccke_pkg::WIN_W-1:0]    r_fwd, n_fwd;
    logic [ccke_pkg::WIN_W-1:0]    r_rev, n_rev;
    logic [ccke_pkg::K_W-1:0]      r_run, n_run;
    logic [ccke_pkg::POS_W-1:0]    r_pos;
    logic                          r_vld;
    logic                          r_full, n_full;
    logic [ccke_pkg::HALF_W-1:0]   r_half;
    logic [ccke_pkg::POS_W-1:0]    r_cpos;
    logic [ccke_pkg::CONTIG_W-1:0] r_tag;

    logic [ccke_pkg::K_W-1:0]      k_eff;
    logic [ccke_pkg::WIN_W-1:0]    mask;
    logic [ccke_pkg::WIN_W-1:0]    cur_fwd, cur_rev, rev_ins;
    logic [ccke_pkg::K_W-1:0]      cur_run;
    logic [ccke_pkg::POS_W-1:0]    cur_pos;
    ccke_pkg::t_decode             dec;
    logic                          accept;

    assign i_cfg.ready  = 1'b1;
    assign i_kmer.ready = !r_vld || i_take;
    assign accept       = i_kmer.valid && i_kmer.ready;

    always_comb begin
        if (r_kmer_length < ccke_pkg::K_W'(ccke_pkg::MIN_K)) begin
            k_eff = ccke_pkg::K_W'(ccke_pkg::MIN_K);
        end else if (r_kmer_length > ccke_pkg::K_W'(ccke_pkg::MAX_K)) begin
            k_eff = ccke_pkg::K_W'(ccke_pkg::MAX_K);
        end else begin
            k_eff = r_kmer_length;
        end
    end

    assign mask = ccke_pkg::win_mask(k_eff);
    assign dec  = ccke_pkg::decode_base(i_kmer.base_char);

    // A new sequence starts from empty state
    assign cur_fwd = i_kmer.seq_start ? '0 : r_fwd;
    assign cur_rev = i_kmer.seq_start ? '0 : r_rev;
    assign cur_run = i_kmer.seq_start ? '0 : r_run;
    assign cur_pos = i_kmer.seq_start ? '0 : r_pos;

    assign rev_ins = ccke_pkg::WIN_W'(~dec.code)
                     << ccke_pkg::SH_W'({ccke_pkg::K_W'(k_eff - ccke_pkg::K_W'(1)), 1'b0});

    always_comb begin
        if (dec.hit) begin
            n_fwd  = ((cur_fwd << 2) | ccke_pkg::WIN_W'(dec.code)) & mask;
            n_rev  = ((cur_rev >> 2) | rev_ins) & mask;
            n_run  = (cur_run < k_eff) ? ccke_pkg::K_W'(cur_run + ccke_pkg::K_W'(1)) : cur_run;
            n_full = (n_run >= k_eff);
        end else begin
            n_fwd  = '0;
            n_rev  = '0;
            n_run  = '0;
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= ccke_pkg::K_RESET;
        end else if (i_cfg.valid) begin
            r_kmer_length <= i_cfg.kmer_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= '0;
            r_rev <= '0;
            r_run <= '0;
            r_pos <= '0;
            r_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_fwd <= n_fwd;
                r_rev <= n_rev;
                r_run <= n_run;
                r_pos <= cur_pos + ccke_pkg::POS_W'(1);
                r_vld <= 1'b1;
            end else if (i_take) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_full <= n_full;
            r_half <= k_eff[ccke_pkg::K_W-1:1];
            r_cpos <= cur_pos - ccke_pkg::POS_W'(k_eff[ccke_pkg::K_W-1:1]);
            r_tag  <= i_kmer.contig_index & ccke_pkg::CONTIG_MASK;
        end
    end

    assign o_stage.vld             = r_vld;
    assign o_stage.full            = r_full;
    assign o_stage.fwd             = r_fwd;
    assign o_stage.rev             = r_rev;
    assign o_stage.half            = r_half;
    assign o_stage.center_position = r_cpos;
    assign o_stage.contig_tag      = r_tag;

    a_start_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_kmer.seq_start |=> r_pos == ccke_pkg::POS_W'(1))
        else $error("position not restarted on new sequence");

    a_break_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !dec.hit |=> r_run == '0 && r_fwd == '0 && r_rev == '0)
        else $error("run not broken by non-base character");

    a_hold_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_take |=> r_vld && $stable(r_fwd) && $stable(r_rev))
        else $error("stage one lost a held request");

endmodule

@@ hw/rtl/ccke_flank.sv @@
// Canonical pick, center removal, palindrome drop and output register (stage two).
module ccke_flank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ccke_pkg::t_stage     i_stage,
    output logic                 o_take,
    ccke_out_if.source           o_site
);

    logic                           r_out_vld;
    logic [ccke_pkg::FLANK_W-1:0]   r_flank;
    logic [ccke_pkg::CODE_W-1:0]    r_center;
    logic [ccke_pkg::POS_W-1:0]     r_cpos;
    logic [ccke_pkg::CONTIG_W-1:0]  r_tag;

    logic [ccke_pkg::FLANK_W-1:0]   fl_fwd, fl_rev;
    logic                           fwd_small;
    logic [ccke_pkg::WIN_W-1:0]     canon;
    logic [ccke_pkg::WIN_W-1:0]     center_shift;
    logic                           emit;

    assign fl_fwd    = ccke_pkg::remove_center(i_stage.fwd, i_stage.half);
    assign fl_rev    = ccke_pkg::remove_center(i_stage.rev, i_stage.half);
    assign fwd_small = i_stage.fwd < i_stage.rev;
    assign canon     = fwd_small ? i_stage.fwd : i_stage.rev;
    assign center_shift = canon >> ccke_pkg::SH_W'({i_stage.half, 1'b0});

    // Drop palindromic flanks
    assign emit   = i_stage.vld && i_stage.full && (fl_fwd != fl_rev);
    assign o_take = !r_out_vld || o_site.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_take) begin
            r_out_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_flank  <= fwd_small ? fl_fwd : fl_rev;
            r_center <= center_shift[ccke_pkg::CODE_W-1:0];
            r_cpos   <= i_stage.center_position;
            r_tag    <= i_stage.contig_tag;
        end
    end

    assign o_site.valid           = r_out_vld;
    assign o_site.flank_bits      = r_flank;
    assign o_site.center_base     = r_center;
    assign o_site.center_position = r_cpos;
    assign o_site.contig_tag      = r_tag;

    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_stage.vld) && $past(i_stage.full))
        else $error("result raised without a full k-mer");

    a_no_pal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_stage.vld && i_stage.full && fl_fwd == fl_rev |=> !r_out_vld)
        else $error("palindromic k-mer emitted");

endmodule

@@ hw/rtl/canonical_center_kmer_extractor_core.sv @@
// Top level of the canonical center k-mer extractor.
// Takes one sequence character per request and returns at most one k-mer site per
// character. Each accepted character is held in the window stage register, where
// the forward and reverse-complement windows roll. While it is held there, the flank
// stage picks the canonical orientation, splits off its center base and drops
// palindromic flanks, and the site is loaded into the output register when the flank
// stage takes the request. o_site.valid comes from the output register, behind the
// window stage register, and one character is taken every cycle while the output side
// keeps up: the rolling windows are computed combinationally from the held state, so
// consecutive characters never wait on each other. A stall on o_site backs up into
// i_kmer.ready after one held request. Characters that break the run, that do not
// yet complete k bases, or whose flanks read the same in both orientations yield no
// site. The k-mer length on i_cfg resets to 31, is clamped to 3..31, and should be
// written only while no request is in flight; an even length is used as given with
// the center at base k/2 from the low end.
module canonical_center_kmer_extractor_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccke_cfg_if.sink      i_cfg,
    ccke_in_if.sink       i_kmer,
    ccke_out_if.source    o_site
);

    // Stage-one request and the flank stage's permission to advance it
    ccke_pkg::t_stage     stage;
    logic                 take;

    // Roll windows, count the run, advance the position
    ccke_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_kmer  (i_kmer),
        .i_take  (take),
        .o_stage (stage)
    );

    // Pick canonical k-mer, strip center, drop palindromes, hold the site
    ccke_flank u_flank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .o_take  (take),
        .o_site  (o_site)
    );

endmodule
